>>> rtl/core/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared constants, types, microprogram and letter tables for the
// integer to roman numeral converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int MAX_THOUSANDS = 3;
   localparam int VALUE_W       = 12;
   localparam int LETTER_W      = 8;
   localparam int TH_W          = 3;
   localparam int K_W           = 3;
   localparam int STEP_W        = 4;
   localparam int DIGIT_W       = 4;
   localparam int R1_W          = 10;
   localparam int R2_W          = 7;

   // reciprocal multipliers for the digit split
   localparam int RCP_TH_W   = 13;
   localparam int RCP_TH     = 4195;
   localparam int RCP_TH_SH  = 22;
   localparam int RCP_HU_W   = 6;
   localparam int RCP_HU     = 41;
   localparam int RCP_HU_SH  = 12;
   localparam int RCP_TE_W   = 8;
   localparam int RCP_TE     = 205;
   localparam int RCP_TE_SH  = 11;

   localparam logic [STEP_W-1:0] STEP_EMPTY = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_BIG   = STEP_W'(9);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CHECK,
      OP_EMIT,
      OP_EMPTY,
      OP_BIG
   } op_type;

   typedef enum logic [1:0] {
      DIG_TH,
      DIG_HU,
      DIG_TE,
      DIG_ON
   } digit_type;

   typedef enum logic [1:0] {
      SEL_UNIT,
      SEL_FIVE,
      SEL_TEN
   } sel_type;

   typedef struct packed {
      logic                ld_th;
      logic                ld_r1;
      logic                ld_hu;
      logic                ld_r2;
      logic                ld_te;
      logic                ld_on;
      op_type              op;
      digit_type           digit;
      logic                fin;
      logic [STEP_W-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic is_zero;
      logic is_big;
      logic digit_done;
   } stat_type;

   function automatic ctrl_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_type c;
      c = '0;
      case (step)
         4'd0: begin
            c.ld_th = 1'b1;
         end
         4'd1: begin
            c.ld_r1  = 1'b1;
            c.op     = OP_CHECK;
            c.target = STEP_EMPTY;
         end
         4'd2: begin
            c.ld_hu = 1'b1;
         end
         4'd3: begin
            c.ld_r2 = 1'b1;
         end
         4'd4: begin
            c.ld_te = 1'b1;
            c.op    = OP_EMIT;
            c.digit = DIG_TH;
         end
         4'd5: begin
            c.ld_on = 1'b1;
            c.op    = OP_EMIT;
            c.digit = DIG_HU;
         end
         4'd6: begin
            c.op    = OP_EMIT;
            c.digit = DIG_TE;
         end
         4'd7: begin
            c.op    = OP_EMIT;
            c.digit = DIG_ON;
            c.fin   = 1'b1;
         end
         4'd8: begin
            c.op  = OP_EMPTY;
            c.fin = 1'b1;
         end
         4'd9: begin
            c.op  = OP_BIG;
            c.fin = 1'b1;
         end
         default: begin
            c.fin = 1'b1;
         end
      endcase
      return c;
   endfunction

   function automatic logic [K_W-1:0] pat_len(input logic [DIGIT_W-1:0] d);
      logic [K_W-1:0] n;
      case (d)
         4'd1, 4'd5:       n = K_W'(1);
         4'd2, 4'd4, 4'd6,
         4'd9:             n = K_W'(2);
         4'd3, 4'd7:       n = K_W'(3);
         4'd8:             n = K_W'(4);
         default:          n = '0;
      endcase
      return n;
   endfunction

   function automatic sel_type pat_sel(input logic [DIGIT_W-1:0] d,
                                       input logic [K_W-1:0] k);
      sel_type s;
      s = SEL_UNIT;
      case (d)
         4'd4: s = (k == K_W'(0)) ? SEL_UNIT : SEL_FIVE;
         4'd5, 4'd6, 4'd7, 4'd8:
               s = (k == K_W'(0)) ? SEL_FIVE : SEL_UNIT;
         4'd9: s = (k == K_W'(0)) ? SEL_UNIT : SEL_TEN;
         default: s = SEL_UNIT;
      endcase
      return s;
   endfunction

   function automatic logic [LETTER_W-1:0] digit_char(input digit_type g,
                                                      input sel_type s);
      logic [LETTER_W-1:0] ch;
      ch = "M";
      case (g)
         DIG_HU: begin
            case (s)
               SEL_UNIT: ch = "C";
               SEL_FIVE: ch = "D";
               default:  ch = "M";
            endcase
         end
         DIG_TE: begin
            case (s)
               SEL_UNIT: ch = "X";
               SEL_FIVE: ch = "L";
               default:  ch = "C";
            endcase
         end
         DIG_ON: begin
            case (s)
               SEL_UNIT: ch = "I";
               SEL_FIVE: ch = "V";
               default:  ch = "X";
            endcase
         end
         default: ch = "M";
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/core/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit unsigned number into its Roman numeral, one ASCII letter
// per result beat, most significant letter first.
//
// A number is taken when start is high and busy is low. A small microprogram
// steps through its control store: four steps load the thousands, the
// hundreds and their remainders, and the tens and ones are loaded during the
// first two digit steps. Each of the four digit steps holds while it gives its
// letters, or passes on when it gives none; busy stays high until the last
// step is done. Zero and too-large numbers give one flagged beat. Result beats
// appear on rsp_valid for one cycle each, one letter per beat, and cannot
// be held off; rsp_last marks the final beat of each number.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [i2r_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   output logic [i2r_pkg::LETTER_W-1:0]  rsp_letter,
   output logic                          rsp_empty_res,
   output logic                          rsp_too_large,
   output logic                          rsp_last
);

   logic              accept;
   i2r_pkg::ctrl_type ctrl;
   i2r_pkg::stat_type stat;

   assign accept = start && !busy;

   i2r_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   i2r_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .value         (req_value),
      .ctrl          (ctrl),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_letter    (rsp_letter),
      .rsp_empty_res (rsp_empty_res),
      .rsp_too_large (rsp_too_large),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_flag_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_empty_res || rsp_too_large)) |-> rsp_last)
      else $error("flagged beat not last");

   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_res && rsp_too_large))
      else $error("empty and too large together");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("run ended without last beat");
`endif

endmodule

>>> rtl/core/i2r_seq.sv
// ----------------------------------------------------------------------------
// i2r_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module i2r_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  i2r_pkg::stat_type stat,
   output logic              busy,
   output i2r_pkg::ctrl_type ctrl
);

   logic [i2r_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   i2r_pkg::ctrl_type          word;

   assign word = i2r_pkg::rom_word(step_ff);
   assign ctrl = busy_ff ? word : '0;
   assign busy = busy_ff;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (accept) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (word.op == i2r_pkg::OP_EMIT && !stat.digit_done) begin
            step_in = step_ff;
         end else if (word.fin) begin
            busy_in = 1'b0;
         end else if (word.op == i2r_pkg::OP_CHECK && stat.is_zero) begin
            step_in = word.target;
         end else if (word.op == i2r_pkg::OP_CHECK && stat.is_big) begin
            step_in = word.target + i2r_pkg::STEP_W'(1);
         end else begin
            step_in = step_ff + i2r_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> rtl/core/i2r_dp.sv
// ----------------------------------------------------------------------------
// i2r_dp
// Datapath: digit split by reciprocal multiply, letter counter and the
// registered result beat.
// ----------------------------------------------------------------------------
module i2r_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [i2r_pkg::VALUE_W-1:0]      value,
   input  i2r_pkg::ctrl_type                ctrl,
   output i2r_pkg::stat_type                stat,
   output logic                             rsp_valid,
   output logic [i2r_pkg::LETTER_W-1:0]     rsp_letter,
   output logic                             rsp_empty_res,
   output logic                             rsp_too_large,
   output logic                             rsp_last
);

   localparam int PTH_W = i2r_pkg::VALUE_W + i2r_pkg::RCP_TH_W;
   localparam int PHU_W = i2r_pkg::R1_W + i2r_pkg::RCP_HU_W;
   localparam int PTE_W = i2r_pkg::R2_W + i2r_pkg::RCP_TE_W;

   logic [i2r_pkg::VALUE_W-1:0]  value_ff;
   logic [i2r_pkg::TH_W-1:0]     th_ff;
   logic [i2r_pkg::R1_W-1:0]     r1_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  hu_ff;
   logic [i2r_pkg::R2_W-1:0]     r2_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  te_ff;
   logic [i2r_pkg::DIGIT_W-1:0]  on_ff;
   logic [i2r_pkg::K_W-1:0]      k_ff, k_in;

   logic [PTH_W-1:0]             prod_th;
   logic [PHU_W-1:0]             prod_hu;
   logic [PTE_W-1:0]             prod_te;
   logic [i2r_pkg::VALUE_W-1:0]  th_scaled;
   logic [i2r_pkg::R1_W-1:0]     hu_scaled;
   logic [i2r_pkg::R2_W-1:0]     te_scaled;

   logic [i2r_pkg::K_W-1:0]      cur_len;
   logic                         lower_zero;
   logic                         digit_done;
   logic                         emit;
   i2r_pkg::sel_type             sel;

   logic                         valid_ff, valid_in;
   logic [i2r_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                         empty_ff, empty_in;
   logic                         big_ff, big_in;
   logic                         last_ff, last_in;

   // digit split
   assign prod_th   = PTH_W'(value_ff) * PTH_W'(i2r_pkg::RCP_TH);
   assign th_scaled = i2r_pkg::VALUE_W'(th_ff) * i2r_pkg::VALUE_W'(1000);
   assign prod_hu   = PHU_W'(r1_ff) * PHU_W'(i2r_pkg::RCP_HU);
   assign hu_scaled = i2r_pkg::R1_W'(hu_ff) * i2r_pkg::R1_W'(100);
   assign prod_te   = PTE_W'(r2_ff) * PTE_W'(i2r_pkg::RCP_TE);
   assign te_scaled = i2r_pkg::R2_W'(te_ff) * i2r_pkg::R2_W'(10);

   always_ff @(posedge clock) begin
      if (accept) value_ff <= value;
      if (ctrl.ld_th) th_ff <= prod_th[i2r_pkg::RCP_TH_SH +: i2r_pkg::TH_W];
      if (ctrl.ld_r1) r1_ff <= i2r_pkg::R1_W'(value_ff - th_scaled);
      if (ctrl.ld_hu) hu_ff <= prod_hu[i2r_pkg::RCP_HU_SH +: i2r_pkg::DIGIT_W];
      if (ctrl.ld_r2) r2_ff <= i2r_pkg::R2_W'(r1_ff - hu_scaled);
      if (ctrl.ld_te) te_ff <= prod_te[i2r_pkg::RCP_TE_SH +: i2r_pkg::DIGIT_W];
      if (ctrl.ld_on) on_ff <= i2r_pkg::DIGIT_W'(r2_ff - te_scaled);
   end

   // letter selection
   always_comb begin
      cur_len    = th_ff;
      lower_zero = (r1_ff == '0);
      sel        = i2r_pkg::SEL_UNIT;
      case (ctrl.digit)
         i2r_pkg::DIG_HU: begin
            cur_len    = i2r_pkg::pat_len(hu_ff);
            lower_zero = (r2_ff == '0);
            sel        = i2r_pkg::pat_sel(hu_ff, k_ff);
         end
         i2r_pkg::DIG_TE: begin
            cur_len    = i2r_pkg::pat_len(te_ff);
            lower_zero = (on_ff == '0);
            sel        = i2r_pkg::pat_sel(te_ff, k_ff);
         end
         i2r_pkg::DIG_ON: begin
            cur_len    = i2r_pkg::pat_len(on_ff);
            lower_zero = 1'b1;
            sel        = i2r_pkg::pat_sel(on_ff, k_ff);
         end
         default: begin
            cur_len    = th_ff;
            lower_zero = (r1_ff == '0);
            sel        = i2r_pkg::SEL_UNIT;
         end
      endcase
   end

   assign digit_done = (cur_len == '0) || (k_ff + i2r_pkg::K_W'(1) == cur_len);
   assign emit       = (ctrl.op == i2r_pkg::OP_EMIT) && (cur_len != '0);

   assign stat.is_zero    = (value_ff == '0);
   assign stat.is_big     = 32'(th_ff) > i2r_pkg::MAX_THOUSANDS;
   assign stat.digit_done = digit_done;

   always_comb begin
      k_in = k_ff;
      if (accept) begin
         k_in = '0;
      end else if (ctrl.op == i2r_pkg::OP_EMIT) begin
         k_in = digit_done ? '0 : k_ff + i2r_pkg::K_W'(1);
      end
   end

   always_comb begin
      valid_in  = emit || ctrl.op == i2r_pkg::OP_EMPTY || ctrl.op == i2r_pkg::OP_BIG;
      letter_in = emit ? i2r_pkg::digit_char(ctrl.digit, sel) : '0;
      empty_in  = (ctrl.op == i2r_pkg::OP_EMPTY);
      big_in    = (ctrl.op == i2r_pkg::OP_BIG);
      last_in   = emit ? (digit_done && lower_zero) : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      empty_ff  <= empty_in;
      big_ff    <= big_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_letter    = letter_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_too_large = big_ff;
   assign rsp_last      = last_ff;

endmodule

>>> test/integer_to_roman_numeral_tb.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb
// Sends numbers into the converter and compares every result beat with
// letters that are predicted locally. Directed values cover the digit
// patterns, the field extremes and the zero and too-large flags. Random
// values with random sender gaps follow.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_tb;

   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_VALUES = 300;

   typedef logic [i2r_pkg::LETTER_W-1:0] letter_type;

   typedef struct {
      letter_type letter;
      logic       empty_res;
      logic       too_large;
      logic       last;
   } numeral_beat_type;

   class numeral_board;
      numeral_beat_type pending[$];
      letter_type       spelling[$];
      int               errors;
      int               letters;
      int               flagged;

      function new();
         errors  = 0;
         letters = 0;
         flagged = 0;
      endfunction

      task report(string field, int got, int want);
         $display("MISMATCH %s: got %0h expected %0h", field, got, want);
         errors++;
      endtask

      function void spell_digit(int d, letter_type unit, letter_type five,
                                letter_type ten);
         case (d)
            1, 2, 3: begin
               repeat (d) spelling.push_back(unit);
            end
            4: begin
               spelling.push_back(unit);
               spelling.push_back(five);
            end
            5, 6, 7, 8: begin
               spelling.push_back(five);
               repeat (d - 5) spelling.push_back(unit);
            end
            9: begin
               spelling.push_back(unit);
               spelling.push_back(ten);
            end
            default: begin
            end
         endcase
      endfunction

      function void note_value(logic [i2r_pkg::VALUE_W-1:0] v);
         int               th;
         numeral_beat_type b;
         th          = v / 1000;
         b.letter    = '0;
         b.empty_res = 1'b0;
         b.too_large = 1'b0;
         b.last      = 1'b1;
         if (v == 0) begin
            b.empty_res = 1'b1;
            pending.push_back(b);
         end else if (th > i2r_pkg::MAX_THOUSANDS) begin
            b.too_large = 1'b1;
            pending.push_back(b);
         end else begin
            spelling.delete();
            repeat (th) spelling.push_back("M");
            spell_digit((v % 1000) / 100, "C", "D", "M");
            spell_digit((v % 100) / 10, "X", "L", "C");
            spell_digit(v % 10, "I", "V", "X");
            foreach (spelling[k]) begin
               b.letter = spelling[k];
               b.last   = (k == spelling.size() - 1);
               pending.push_back(b);
            end
         end
      endfunction

      task check_beat(letter_type letter, logic empty_res, logic too_large, logic last);
         numeral_beat_type want;
         if (pending.size() == 0) begin
            report("beat with nothing expected, letter", int'(letter), 0);
         end else begin
            want = pending.pop_front();
            if (letter !== want.letter)
               report("letter", int'(letter), int'(want.letter));
            if (empty_res !== want.empty_res)
               report("empty_res", int'(empty_res), int'(want.empty_res));
            if (too_large !== want.too_large)
               report("too_large", int'(too_large), int'(want.too_large));
            if (last !== want.last)
               report("last", int'(last), int'(want.last));
         end
         if (empty_res || too_large) flagged++;
         else letters++;
      endtask
   endclass

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic [i2r_pkg::VALUE_W-1:0]   req_value = '0;
   logic                          busy;
   logic                          rsp_valid;
   letter_type                    rsp_letter;
   logic                          rsp_empty_res;
   logic                          rsp_too_large;
   logic                          rsp_last;

   numeral_board sb;
   int           values_sent = 0;
   int           idle_cycles = 0;

   int corner_values[24] = '{0, 1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 500, 900,
                             999, 1000, 3000, 3888, 3999, 4000, 4095, 1365, 2730, 2047};

   integer_to_roman_numeral u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_letter    (rsp_letter),
      .rsp_empty_res (rsp_empty_res),
      .rsp_too_large (rsp_too_large),
      .rsp_last      (rsp_last)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_beat(rsp_letter, rsp_empty_res, rsp_too_large, rsp_last);
      end
   end

   always @(posedge clock) begin
      if ((start && !busy && !reset) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("integer_to_roman_numeral_tb: errors");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task send_value(input logic [i2r_pkg::VALUE_W-1:0] v, input int gap);
      req_value <= v;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_value(v);
      values_sent++;
      @(negedge clock);
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= i2r_pkg::VALUE_W'($urandom);
         repeat (gap) @(negedge clock);
      end
   endtask

   task wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic [i2r_pkg::VALUE_W-1:0] pick_value();
      int mode;
      mode = $urandom_range(0, 9);
      case (mode)
         0, 1, 2, 3, 4, 5:
            return i2r_pkg::VALUE_W'(1000 * $urandom_range(0, i2r_pkg::MAX_THOUSANDS)
                   + 100 * $urandom_range(0, 9)
                   + 10 * $urandom_range(0, 9) + $urandom_range(0, 9));
         6, 7:
            return i2r_pkg::VALUE_W'($urandom_range(0, 4095));
         8:
            return ($urandom_range(0, 3) == 0) ? '0
                   : i2r_pkg::VALUE_W'($urandom_range((i2r_pkg::MAX_THOUSANDS + 1) * 1000,
                                                      4095));
         default:
            return i2r_pkg::VALUE_W'($urandom_range(1, 99));
      endcase
   endfunction

   initial begin
      int gap;
      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (corner_values[i]) begin
         send_value(i2r_pkg::VALUE_W'(corner_values[i]), $urandom_range(0, 9));
      end
      wait_drained();

      // every third stretch of 40 values runs back to back
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
         if (i == RANDOM_VALUES / 2) wait_drained();
         send_value(pick_value(), gap);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d values: %0d letter beats, %0d zero or too-large beats",
               values_sent, sb.letters, sb.flagged);
      if (sb.errors == 0) begin
         $display("integer_to_roman_numeral_tb: clean");
      end else begin
         $display("integer_to_roman_numeral_tb: errors");
      end
      $finish;
   end

endmodule
